/* rtl/bal_pkg.sv */
// Shared types and codes for the banker's allocator.
// No dependencies; the row unit, the top level and both testbench files import this package.
package bal_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_AVAIL = 2'd0,
        OP_LOAD_ROW   = 2'd1,
        OP_REQUEST    = 2'd2,
        OP_RELEASE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_LOADED    = 3'd0,
        ST_GRANTED   = 3'd1,
        ST_EXCEEDS   = 3'd2,
        ST_SHORT     = 3'd3,
        ST_RELEASED  = 3'd4,
        ST_EVICTED   = 3'd5,
        ST_UNRECOV   = 3'd6
    } t_status;

    localparam logic CFG_ACT_PROC = 1'b0;
    localparam logic CFG_ACT_RES  = 1'b1;

    localparam int MAX_RES = 4;

    // Flags produced by the row unit for the sequencer.
    typedef struct packed {
        logic       fits;
        logic       over;
        logic       short_av;
        logic [3:0] ovr;
    } t_row_flags;

endpackage

/* rtl/bal_if.sv */
// Handshake interfaces for the allocator: request, result and configuration channels.
// Depends on nothing; payload widths are fixed by the item format.
interface bal_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [2:0] pid;
    logic [7:0] amount_0;
    logic [7:0] amount_1;
    logic [7:0] amount_2;
    logic [7:0] amount_3;
    logic [7:0] limit_0;
    logic [7:0] limit_1;
    logic [7:0] limit_2;
    logic [7:0] limit_3;
    modport source (output valid, operation, pid, amount_0, amount_1, amount_2, amount_3,
                    limit_0, limit_1, limit_2, limit_3, input ready);
    modport sink (input valid, operation, pid, amount_0, amount_1, amount_2, amount_3,
                  limit_0, limit_1, limit_2, limit_3, output ready);
endinterface

interface bal_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] victim;
    logic [3:0] over_release;
    logic       last;
    modport source (output valid, status, victim, over_release, last, input ready);
    modport sink (input valid, status, victim, over_release, last, output ready);
endinterface

interface bal_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/bal_row_unit.sv */
// Shared row arithmetic: works on one process row, all resource lanes at once.
// Depends on bal_pkg for the flag struct.
module bal_row_unit import bal_pkg::*; #(
    parameter int RESOURCES  = 4,
    parameter int COUNT_BITS = 8,
    parameter int WW         = 12
) (
    input  logic                          i_valid,
    input  logic [2:0]                    i_nr,
    input  logic [7:0]                    i_amt   [MAX_RES],
    input  logic [7:0]                    i_lim   [MAX_RES],
    input  logic [COUNT_BITS-1:0]         i_alloc [RESOURCES],
    input  logic [COUNT_BITS-1:0]         i_claim [RESOURCES],
    input  logic signed [COUNT_BITS:0]    i_need  [RESOURCES],
    input  logic [COUNT_BITS-1:0]         i_avail [RESOURCES],
    input  logic [WW-1:0]                 i_work  [RESOURCES],
    output t_row_flags                    o_flags,
    output logic [COUNT_BITS+1:0]         o_sum,
    output logic [WW-1:0]                 o_work_add   [RESOURCES],
    output logic [COUNT_BITS-1:0]         o_amt_sat    [RESOURCES],
    output logic [COUNT_BITS-1:0]         o_lim_sat    [RESOURCES],
    output logic signed [COUNT_BITS:0]    o_need_load  [RESOURCES],
    output logic [COUNT_BITS-1:0]         o_avail_rel  [RESOURCES],
    output logic [COUNT_BITS-1:0]         o_alloc_rel  [RESOURCES],
    output logic [COUNT_BITS-1:0]         o_avail_evict[RESOURCES],
    output logic [COUNT_BITS-1:0]         o_alloc_grant[RESOURCES],
    output logic [COUNT_BITS-1:0]         o_avail_grant[RESOURCES],
    output logic signed [COUNT_BITS:0]    o_need_grant [RESOURCES]
);

    localparam logic [17:0] CMAX = 18'((1 << COUNT_BITS) - 1);

    function automatic logic [COUNT_BITS-1:0] f_sat(input logic [17:0] v);
        logic [COUNT_BITS-1:0] res;
        if (v > CMAX) begin
            res = '1;
        end else begin
            res = v[COUNT_BITS-1:0];
        end
        return res;
    endfunction

    always_comb begin
        logic [17:0] amt;
        logic [17:0] held;
        logic [17:0] back;
        logic [17:0] ag;
        logic        act;
        o_flags = '0;
        o_flags.fits = 1'b1;
        o_flags.over = !i_valid;
        o_sum = '0;
        for (int r = 0; r < RESOURCES; r++) begin
            act  = 3'(r) < i_nr;
            amt  = 18'(i_amt[r]);
            held = i_valid ? 18'(i_alloc[r]) : 18'd0;
            back = (held < amt) ? held : amt;
            if (act) begin
                if (24'(i_need[r]) > $signed({1'b0, 23'(i_work[r])})) begin
                    o_flags.fits = 1'b0;
                end
                if ($signed({1'b0, amt}) > 19'(i_need[r])) begin
                    o_flags.over = 1'b1;
                end
                if (amt > 18'(i_avail[r])) begin
                    o_flags.short_av = 1'b1;
                end
                if (held < amt) begin
                    o_flags.ovr[r] = 1'b1;
                end
                o_sum = o_sum + (COUNT_BITS+2)'(i_alloc[r]);
            end
            o_work_add[r]    = i_work[r] + WW'(i_alloc[r]);
            o_amt_sat[r]     = f_sat(amt);
            o_lim_sat[r]     = f_sat(18'(i_lim[r]));
            o_need_load[r]   = (COUNT_BITS+1)'($signed({1'b0, f_sat(18'(i_lim[r]))})
                                 - $signed({1'b0, f_sat(amt)}));
            o_avail_rel[r]   = f_sat(18'(i_avail[r]) + back);
            o_alloc_rel[r]   = COUNT_BITS'(held - back);
            o_avail_evict[r] = f_sat(18'(i_avail[r]) + 18'(i_alloc[r]));
            ag               = 18'(i_alloc[r]) + amt;
            o_alloc_grant[r] = f_sat(ag);
            o_avail_grant[r] = COUNT_BITS'(18'(i_avail[r]) - amt);
            o_need_grant[r]  = (COUNT_BITS+1)'($signed({1'b0, i_claim[r]})
                                 - $signed({1'b0, f_sat(ag)}));
        end
    end

endmodule

/* rtl/bankers_allocation_with_recovery.sv */
// Top level of the banker's allocator: channel ports, state tables and the sequencer.
// Depends on bal_pkg, the interfaces in bal_if.sv and the row unit bal_row_unit.
//
//  Channel   Dir  Handshake      Payload
//  i_req     in   valid/ready    operation, pid, amount_0..3, limit_0..3
//  o_res     out  valid/ready    status, victim, over_release, last
//  i_cfg     in   valid/ready    index (0 process count, 1 resource count), data
//
// Loads, releases and rejected requests pass the execute and last states only.
// A request that is granted runs the safety check: one process row per cycle
// through the shared row unit, up to P+1 passes until no process finishes,
// then one row per cycle to find a victim; each eviction restarts the check.
// Reset is synchronous and clears all tables. The block takes no new transaction
// until the last result of the current one has been placed in the output
// register; a stalled consumer simply holds the sequencer where it emits.
module bankers_allocation_with_recovery import bal_pkg::*; #(
    parameter int PROCESSES  = 8,
    parameter int RESOURCES  = 4,
    parameter int COUNT_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bal_in_if.sink     i_req,
    bal_out_if.source  o_res,
    bal_cfg_if.sink    i_cfg
);

    localparam int PIW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int NPW = $clog2(PROCESSES + 1);
    localparam int WW  = COUNT_BITS + $clog2(PROCESSES + 1);
    localparam int CB  = COUNT_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_SINIT = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_VSCAN = 7'b0010000,
        S_VDEC  = 7'b0100000,
        S_LAST  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [3:0] r_act_proc;
    logic [2:0] r_act_res;

    // Latched transaction.
    logic [1:0] r_op;
    logic [2:0] r_pid;
    logic [7:0] r_amt [MAX_RES];
    logic [7:0] r_lim [MAX_RES];

    // Allocator state.
    logic [CB-1:0]        r_avail [RESOURCES];
    logic [CB-1:0]        r_alloc [PROCESSES][RESOURCES];
    logic [CB-1:0]        r_claim [PROCESSES][RESOURCES];
    logic signed [CB:0]   r_need  [PROCESSES][RESOURCES];
    logic [WW-1:0]        r_work  [RESOURCES];
    logic [PROCESSES-1:0] r_done;

    // Sequencer registers.
    logic [PIW-1:0] r_idx;
    logic [NPW-1:0] r_count;
    logic           r_progress;
    logic [CB+1:0]  r_best;
    logic [PIW-1:0] r_victim;

    // Pending result and output register.
    logic [2:0] r_pstatus;
    logic [2:0] r_pvictim;
    logic [3:0] r_povr;
    logic       r_ovalid;
    logic [2:0] r_ostatus;
    logic [2:0] r_ovictim;
    logic [3:0] r_oovr;
    logic       r_olast;

    logic [NPW-1:0] np;
    logic [2:0]     nr;
    logic           pid_ok;
    logic [PIW-1:0] pid_idx;
    logic           can_emit;
    logic           at_end;
    logic           take;

    t_row_flags          flags;
    logic [CB+1:0]       row_sum;
    logic [WW-1:0]       work_add    [RESOURCES];
    logic [CB-1:0]       amt_sat     [RESOURCES];
    logic [CB-1:0]       lim_sat     [RESOURCES];
    logic signed [CB:0]  need_load   [RESOURCES];
    logic [CB-1:0]       avail_rel   [RESOURCES];
    logic [CB-1:0]       alloc_rel   [RESOURCES];
    logic [CB-1:0]       avail_evict [RESOURCES];
    logic [CB-1:0]       alloc_grant [RESOURCES];
    logic [CB-1:0]       avail_grant [RESOURCES];
    logic signed [CB:0]  need_grant  [RESOURCES];

    // A register value of zero acts as one; values past the parameter clamp to it.
    always_comb begin
        logic [7:0] pid8;
        if (r_act_proc == 4'd0) begin
            np = NPW'(1);
        end else if (6'(r_act_proc) > 6'(PROCESSES)) begin
            np = NPW'(PROCESSES);
        end else begin
            np = NPW'(r_act_proc);
        end
        if (r_act_res == 3'd0) begin
            nr = 3'd1;
        end else if (r_act_res > 3'(RESOURCES)) begin
            nr = 3'(RESOURCES);
        end else begin
            nr = r_act_res;
        end
        pid_ok  = 6'(r_pid) < 6'(np);
        // Row index for an incoming transaction; an inactive pid points at row zero.
        pid8    = (6'(i_req.pid) < 6'(np)) ? {5'd0, i_req.pid} : 8'd0;
        pid_idx = pid8[PIW-1:0];
    end

    assign can_emit = !r_ovalid || o_res.ready;
    assign at_end   = 6'(r_idx) == 6'(np - NPW'(1));
    assign take     = !r_done[r_idx] && flags.fits;

    bal_row_unit #(
        .RESOURCES  (RESOURCES),
        .COUNT_BITS (COUNT_BITS),
        .WW         (WW)
    ) u_row (
        .i_valid       (pid_ok),
        .i_nr          (nr),
        .i_amt         (r_amt),
        .i_lim         (r_lim),
        .i_alloc       (r_alloc[r_idx]),
        .i_claim       (r_claim[r_idx]),
        .i_need        (r_need[r_idx]),
        .i_avail       (r_avail),
        .i_work        (r_work),
        .o_flags       (flags),
        .o_sum         (row_sum),
        .o_work_add    (work_add),
        .o_amt_sat     (amt_sat),
        .o_lim_sat     (lim_sat),
        .o_need_load   (need_load),
        .o_avail_rel   (avail_rel),
        .o_alloc_rel   (alloc_rel),
        .o_avail_evict (avail_evict),
        .o_alloc_grant (alloc_grant),
        .o_avail_grant (avail_grant),
        .o_need_grant  (need_grant)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid        = r_ovalid;
    assign o_res.status       = r_ostatus;
    assign o_res.victim       = r_ovictim;
    assign o_res.over_release = r_oovr;
    assign o_res.last         = r_olast;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == OP_REQUEST && !flags.over && !flags.short_av) begin
                    n_state = S_SINIT;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_SINIT: n_state = S_SCAN;
            S_SCAN: begin
                if (at_end && !(r_progress || take)) begin
                    n_state = (r_count == np) ? S_LAST : S_VSCAN;
                end
            end
            S_VSCAN: begin
                if (at_end) begin
                    n_state = S_VDEC;
                end
            end
            S_VDEC: begin
                if (can_emit) begin
                    n_state = (r_best == '0) ? S_LAST : S_SINIT;
                end
            end
            S_LAST: begin
                if (can_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_act_proc <= 4'd8;
            r_act_res  <= 3'd4;
            r_ovalid   <= 1'b0;
            r_idx      <= '0;
            r_count    <= '0;
            r_progress <= 1'b0;
            r_best     <= '0;
            r_victim   <= '0;
            r_done     <= '0;
            for (int r = 0; r < RESOURCES; r++) begin
                r_avail[r] <= '0;
                r_work[r]  <= '0;
                for (int p = 0; p < PROCESSES; p++) begin
                    r_alloc[p][r] <= '0;
                    r_claim[p][r] <= '0;
                    r_need[p][r]  <= '0;
                end
            end
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_ACT_PROC) begin
                    r_act_proc <= i_cfg.data;
                end else begin
                    r_act_res <= i_cfg.data[2:0];
                end
            end

            // The output register empties when taken, unless a new result
            // is loaded into it at the same edge.
            if (r_ovalid && o_res.ready
                && !(can_emit && (r_state == S_VDEC || r_state == S_LAST))) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op     <= i_req.operation;
                        r_pid    <= i_req.pid;
                        r_idx    <= pid_idx;
                        r_amt[0] <= i_req.amount_0;
                        r_amt[1] <= i_req.amount_1;
                        r_amt[2] <= i_req.amount_2;
                        r_amt[3] <= i_req.amount_3;
                        r_lim[0] <= i_req.limit_0;
                        r_lim[1] <= i_req.limit_1;
                        r_lim[2] <= i_req.limit_2;
                        r_lim[3] <= i_req.limit_3;
                    end
                end
                S_EXEC: begin
                    r_pvictim <= 3'd0;
                    case (r_op)
                        OP_LOAD_AVAIL: begin
                            r_pstatus <= ST_LOADED;
                            r_povr    <= 4'd0;
                            for (int r = 0; r < RESOURCES; r++) begin
                                if (3'(r) < nr) begin
                                    r_avail[r] <= amt_sat[r];
                                end
                            end
                        end
                        OP_LOAD_ROW: begin
                            r_pstatus <= ST_LOADED;
                            r_povr    <= 4'd0;
                            for (int r = 0; r < RESOURCES; r++) begin
                                if (pid_ok && 3'(r) < nr) begin
                                    r_claim[r_idx][r] <= lim_sat[r];
                                    r_alloc[r_idx][r] <= amt_sat[r];
                                    r_need[r_idx][r]  <= need_load[r];
                                end
                            end
                        end
                        OP_RELEASE: begin
                            r_pstatus <= ST_RELEASED;
                            r_povr    <= flags.ovr;
                            for (int r = 0; r < RESOURCES; r++) begin
                                if (pid_ok && 3'(r) < nr) begin
                                    r_avail[r]        <= avail_rel[r];
                                    r_alloc[r_idx][r] <= alloc_rel[r];
                                end
                            end
                        end
                        OP_REQUEST: begin
                            r_povr <= 4'd0;
                            if (flags.over) begin
                                r_pstatus <= ST_EXCEEDS;
                            end else if (flags.short_av) begin
                                r_pstatus <= ST_SHORT;
                            end else begin
                                r_pstatus <= ST_GRANTED;
                                for (int r = 0; r < RESOURCES; r++) begin
                                    if (3'(r) < nr) begin
                                        r_avail[r]        <= avail_grant[r];
                                        r_alloc[r_idx][r] <= alloc_grant[r];
                                        r_need[r_idx][r]  <= need_grant[r];
                                    end
                                end
                            end
                        end
                        default: begin
                            r_pstatus <= ST_LOADED;
                            r_povr    <= 4'd0;
                        end
                    endcase
                end
                S_SINIT: begin
                    // Start a fresh safety check from the current available vector.
                    for (int r = 0; r < RESOURCES; r++) begin
                        r_work[r] <= WW'(r_avail[r]);
                    end
                    r_done     <= '0;
                    r_idx      <= '0;
                    r_count    <= '0;
                    r_progress <= 1'b0;
                end
                S_SCAN: begin
                    if (take) begin
                        r_done[r_idx] <= 1'b1;
                        r_work        <= work_add;
                        r_count       <= r_count + NPW'(1);
                    end
                    if (at_end) begin
                        r_idx      <= '0;
                        r_progress <= 1'b0;
                        r_best     <= '0;
                        r_victim   <= '0;
                    end else begin
                        r_idx      <= r_idx + PIW'(1);
                        r_progress <= r_progress || take;
                    end
                end
                S_VSCAN: begin
                    // Largest allocation sum wins; a tie keeps the earlier process.
                    if (row_sum > r_best) begin
                        r_best   <= row_sum;
                        r_victim <= r_idx;
                    end
                    if (at_end) begin
                        r_idx <= (row_sum > r_best) ? r_idx : r_victim;
                    end else begin
                        r_idx <= r_idx + PIW'(1);
                    end
                end
                S_VDEC: begin
                    if (can_emit) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_pstatus;
                        r_ovictim <= r_pvictim;
                        r_oovr    <= r_povr;
                        r_olast   <= 1'b0;
                        r_povr    <= 4'd0;
                        if (r_best == '0) begin
                            r_pstatus <= ST_UNRECOV;
                            r_pvictim <= 3'd0;
                        end else begin
                            r_pstatus <= ST_EVICTED;
                            r_pvictim <= 3'(r_idx);
                            for (int r = 0; r < RESOURCES; r++) begin
                                if (3'(r) < nr) begin
                                    r_avail[r]        <= avail_evict[r];
                                    r_alloc[r_idx][r] <= '0;
                                    r_need[r_idx][r]  <= $signed({1'b0, r_claim[r_idx][r]});
                                end
                            end
                        end
                    end
                end
                S_LAST: begin
                    if (can_emit) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_pstatus;
                        r_ovictim <= r_pvictim;
                        r_oovr    <= r_povr;
                        r_olast   <= 1'b1;
                    end
                end
                default: r_idx <= '0;
            endcase
        end
    end

endmodule

/* tb/bal_tb_pkg.sv */
// Typed item records used by the allocator testbench.
// Depends on bal_pkg for the operation and status codes.
package bal_tb_pkg;
    import bal_pkg::*;

    typedef struct {
        t_op        op;
        logic [2:0] pid;
        logic [7:0] amt [4];
        logic [7:0] lim [4];
    } t_req_item;

    typedef struct packed {
        t_status    status;
        logic [2:0] victim;
        logic [3:0] ovr;
        logic       last;
    } t_res_item;
endpackage

/* tb/tb_top.sv */
// Self-checking testbench for bankers_allocation_with_recovery.
// Depends on bal_pkg, bal_tb_pkg, the RTL interfaces and the allocator top level.
// Directed table first, then random loads, requests and releases, all scored
// against a behavioral allocator model kept inside this module.
module tb_top;
    import bal_pkg::*;
    import bal_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    bal_in_if  req_ch ();
    bal_out_if res_ch ();
    bal_cfg_if cfg_ch ();

    bankers_allocation_with_recovery u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Allocator model state. Need is kept signed because an allocation can be
    // loaded above its claim.
    int unsigned avail_amt [4];
    int unsigned held_amt  [8][4];
    int unsigned claim_amt [8][4];
    int          need_amt  [8][4];
    int unsigned proc_cfg;
    int unsigned res_cfg;

    t_res_item pending_results [$];
    int        fail_count;
    int        result_count;
    int        evict_count;
    bit        idle_enable;
    bit        hold_off;

    function automatic int unsigned clamp_count(longint unsigned v);
        return (v > 255) ? 255 : int'(v);
    endfunction

    function automatic int unsigned eff_procs();
        if (proc_cfg < 1) return 1;
        if (proc_cfg > 8) return 8;
        return proc_cfg;
    endfunction

    function automatic int unsigned eff_res();
        if (res_cfg < 1) return 1;
        if (res_cfg > 4) return 4;
        return res_cfg;
    endfunction

    function automatic void push_result(t_status st, logic [2:0] vic, logic [3:0] ovr);
        t_res_item it;
        it.status = st;
        it.victim = vic;
        it.ovr    = ovr;
        it.last   = 1'b0;
        pending_results.insert(pending_results.size(), it);
    endfunction

    // Banker's safety test over the active rows and columns.
    function automatic bit state_is_safe(int unsigned np, int unsigned nr);
        longint work [4];
        bit     finished [8];
        int     count;
        bit     progress;
        bit     fits;
        count = 0;
        progress = 1'b1;
        for (int r = 0; r < 4; r++) work[r] = avail_amt[r];
        for (int i = 0; i < 8; i++) finished[i] = 1'b0;
        while (progress) begin
            progress = 1'b0;
            for (int i = 0; i < np; i++) begin
                if (!finished[i]) begin
                    fits = 1'b1;
                    for (int r = 0; r < nr; r++)
                        if (longint'(need_amt[i][r]) > work[r]) fits = 1'b0;
                    if (fits) begin
                        finished[i] = 1'b1;
                        for (int r = 0; r < nr; r++) work[r] += held_amt[i][r];
                        count++;
                        progress = 1'b1;
                    end
                end
            end
        end
        return count == np;
    endfunction

    // Predicts every result of one accepted transaction and updates the model.
    function automatic void predict_allocator(t_req_item it);
        int unsigned np;
        int unsigned nr;
        bit          active_pid;
        bit          over;
        bit          short_av;
        logic [3:0]  ovr;
        int unsigned held;
        int unsigned back;
        int unsigned best;
        int unsigned sum;
        int unsigned vic;
        int          first_idx;
        np = eff_procs();
        nr = eff_res();
        active_pid = it.pid < np;
        first_idx = pending_results.size();
        case (it.op)
            OP_LOAD_AVAIL: begin
                for (int r = 0; r < nr; r++) avail_amt[r] = it.amt[r];
                push_result(ST_LOADED, 3'd0, 4'd0);
            end
            OP_LOAD_ROW: begin
                if (active_pid) begin
                    for (int r = 0; r < nr; r++) begin
                        claim_amt[it.pid][r] = it.lim[r];
                        held_amt[it.pid][r]  = it.amt[r];
                        need_amt[it.pid][r]  = int'(it.lim[r]) - int'(it.amt[r]);
                    end
                end
                push_result(ST_LOADED, 3'd0, 4'd0);
            end
            OP_RELEASE: begin
                ovr = 4'd0;
                for (int r = 0; r < nr; r++) begin
                    held = active_pid ? held_amt[it.pid][r] : 0;
                    if (held < it.amt[r]) ovr[r] = 1'b1;
                    if (active_pid) begin
                        back = (held < it.amt[r]) ? held : it.amt[r];
                        avail_amt[r] = clamp_count(longint'(avail_amt[r]) + back);
                        held_amt[it.pid][r] = held - back;
                    end
                end
                push_result(ST_RELEASED, 3'd0, ovr);
            end
            default: begin
                over = !active_pid;
                short_av = 1'b0;
                if (active_pid) begin
                    for (int r = 0; r < nr; r++) begin
                        if (int'(it.amt[r]) > need_amt[it.pid][r]) over = 1'b1;
                        if (it.amt[r] > avail_amt[r]) short_av = 1'b1;
                    end
                end
                if (over) push_result(ST_EXCEEDS, 3'd0, 4'd0);
                else if (short_av) push_result(ST_SHORT, 3'd0, 4'd0);
                else begin
                    for (int r = 0; r < nr; r++) begin
                        held_amt[it.pid][r] = clamp_count(
                            longint'(held_amt[it.pid][r]) + it.amt[r]);
                        avail_amt[r] -= it.amt[r];
                        need_amt[it.pid][r] = int'(claim_amt[it.pid][r])
                                              - int'(held_amt[it.pid][r]);
                    end
                    push_result(ST_GRANTED, 3'd0, 4'd0);
                    // Recovery: evict the heaviest holder until the state is safe.
                    while (!state_is_safe(np, nr)) begin
                        best = 0;
                        vic = 0;
                        for (int i = 0; i < np; i++) begin
                            sum = 0;
                            for (int r = 0; r < nr; r++) sum += held_amt[i][r];
                            if (sum > best) begin
                                best = sum;
                                vic = i;
                            end
                        end
                        if (best == 0) begin
                            push_result(ST_UNRECOV, 3'd0, 4'd0);
                            break;
                        end
                        for (int r = 0; r < nr; r++) begin
                            avail_amt[r] = clamp_count(
                                longint'(avail_amt[r]) + held_amt[vic][r]);
                            held_amt[vic][r] = 0;
                            need_amt[vic][r] = claim_amt[vic][r];
                        end
                        push_result(ST_EVICTED, vic[2:0], 4'd0);
                    end
                end
            end
        endcase
        pending_results[pending_results.size() - 1].last = 1'b1;
        if (pending_results.size() <= first_idx) fail_count++;
    endfunction

    // Result checker: every transaction on the output is compared with the
    // oldest prediction.
    always @(posedge i_clk) begin
        t_res_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d victim=%0d ovr=%h last=%b",
                         $time, res_ch.status, res_ch.victim, res_ch.over_release,
                         res_ch.last);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.status == ST_EVICTED) evict_count++;
                if (res_ch.status !== want.status || res_ch.victim !== want.victim
                    || res_ch.over_release !== want.ovr || res_ch.last !== want.last) begin
                    $display("%0t: mismatch expected status=%0d victim=%0d ovr=%h last=%b",
                             $time, want.status, want.victim, want.ovr, want.last);
                    $display("%0t:          actual   status=%0d victim=%0d ovr=%h last=%b",
                             $time, res_ch.status, res_ch.victim, res_ch.over_release,
                             res_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 18);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // The block stays busy through at least its execute and last states after each
    // transaction, so waiting for the next falling edge never delays acceptance.
    task automatic send_item(t_req_item it);
        int gap;
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= it.op;
        req_ch.pid       <= it.pid;
        req_ch.amount_0  <= it.amt[0];
        req_ch.amount_1  <= it.amt[1];
        req_ch.amount_2  <= it.amt[2];
        req_ch.amount_3  <= it.amt[3];
        req_ch.limit_0   <= it.lim[0];
        req_ch.limit_1   <= it.lim[1];
        req_ch.limit_2   <= it.lim[2];
        req_ch.limit_3   <= it.lim[3];
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_allocator(it);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    // Waits for all predictions to drain plus a latency margin, then writes.
    task automatic write_register(logic idx, logic [3:0] value);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == CFG_ACT_PROC) proc_cfg = value;
        else res_cfg = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_req_item make_item(t_op op, int pid, int a0, int a1, int a2, int a3,
                                            int l0, int l1, int l2, int l3);
        t_req_item it;
        it.op = op;
        it.pid = pid[2:0];
        it.amt = '{a0[7:0], a1[7:0], a2[7:0], a3[7:0]};
        it.lim = '{l0[7:0], l1[7:0], l2[7:0], l3[7:0]};
        return it;
    endfunction

    // Random content, mostly well-formed: rows with claims at or above holdings,
    // small requests, and modest available amounts.
    function automatic t_req_item random_item();
        t_req_item it;
        int sel;
        sel = $urandom_range(0, 99);
        it.pid = 3'($urandom_range(0, 7));
        for (int r = 0; r < 4; r++) begin
            it.amt[r] = 8'($urandom_range(0, 12));
            it.lim[r] = 8'(it.amt[r] + $urandom_range(0, 20));
        end
        if (sel < 10) it.op = OP_LOAD_AVAIL;
        else if (sel < 30) it.op = OP_LOAD_ROW;
        else if (sel < 75) begin
            it.op = OP_REQUEST;
            for (int r = 0; r < 4; r++) it.amt[r] = 8'($urandom_range(0, 6));
        end else it.op = OP_RELEASE;
        if (sel >= 92) begin
            for (int r = 0; r < 4; r++) begin
                it.amt[r] = 8'($urandom());
                it.lim[r] = 8'($urandom());
            end
        end
        return it;
    endfunction

    // Directed rows. A row with has_check set is also compared against the
    // literal status on its single result.
    typedef struct {
        t_req_item it;
        bit        has_check;
        t_status   check;
    } t_directed_row;

    t_directed_row directed_rows [$];

    function automatic void add_row(t_req_item it, bit chk, t_status st);
        t_directed_row row;
        row.it        = it;
        row.has_check = chk;
        row.check     = st;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    initial begin
        t_directed_row row;
        t_req_item it;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_LOAD_AVAIL;
        req_ch.pid = '0;
        {req_ch.amount_0, req_ch.amount_1, req_ch.amount_2, req_ch.amount_3} = '0;
        {req_ch.limit_0, req_ch.limit_1, req_ch.limit_2, req_ch.limit_3} = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ACT_PROC;
        cfg_ch.data = '0;
        idle_enable = 1'b0;
        hold_off = 1'b0;
        fail_count = 0;
        result_count = 0;
        evict_count = 0;
        proc_cfg = 8;
        res_cfg = 4;
        for (int r = 0; r < 4; r++) avail_amt[r] = 0;
        for (int i = 0; i < 8; i++)
            for (int r = 0; r < 4; r++) begin
                held_amt[i][r] = 0;
                claim_amt[i][r] = 0;
                need_amt[i][r] = 0;
            end

        // After reset nothing is held or claimed, so any nonzero request
        // exceeds the claim and any nonzero release is flagged.
        add_row(make_item(OP_REQUEST, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, ST_EXCEEDS);
        add_row(make_item(OP_RELEASE, 7, 255, 255, 255, 255, 0, 0, 0, 0), 1, ST_RELEASED);
        add_row(make_item(OP_LOAD_AVAIL, 0, 255, 255, 255, 255, 0, 0, 0, 0), 1, ST_LOADED);
        add_row(make_item(OP_LOAD_ROW, 7, 0, 0, 0, 0, 255, 255, 255, 255), 1, ST_LOADED);
        add_row(make_item(OP_REQUEST, 7, 255, 255, 255, 255, 0, 0, 0, 0), 0, ST_LOADED);
        add_row(make_item(OP_RELEASE, 7, 100, 0, 200, 255, 0, 0, 0, 0), 1, ST_RELEASED);
        // Allocation loaded above its claim: negative need rejects a zero request.
        add_row(make_item(OP_LOAD_ROW, 2, 9, 9, 9, 9, 3, 3, 3, 3), 1, ST_LOADED);
        add_row(make_item(OP_REQUEST, 2, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_EXCEEDS);
        // Claim fits but available does not.
        add_row(make_item(OP_LOAD_AVAIL, 0, 1, 1, 1, 1, 0, 0, 0, 0), 1, ST_LOADED);
        add_row(make_item(OP_LOAD_ROW, 1, 0, 0, 0, 0, 50, 50, 50, 50), 1, ST_LOADED);
        add_row(make_item(OP_REQUEST, 1, 5, 0, 0, 0, 0, 0, 0, 0), 1, ST_SHORT);
        // Unsafe grant: evictions follow, possibly ending unrecoverable.
        add_row(make_item(OP_REQUEST, 1, 1, 1, 1, 1, 0, 0, 0, 0), 0, ST_LOADED);
        add_row(make_item(OP_LOAD_ROW, 3, 4, 4, 4, 4, 200, 200, 200, 200), 1, ST_LOADED);
        add_row(make_item(OP_LOAD_ROW, 4, 4, 4, 4, 4, 200, 200, 200, 200), 1, ST_LOADED);
        add_row(make_item(OP_LOAD_AVAIL, 0, 2, 2, 2, 2, 0, 0, 0, 0), 1, ST_LOADED);
        add_row(make_item(OP_REQUEST, 1, 2, 2, 2, 2, 0, 0, 0, 0), 0, ST_LOADED);
        add_row(make_item(OP_RELEASE, 3, 170, 85, 15, 240, 0, 0, 0, 0), 1, ST_RELEASED);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.has_check) begin
                // Let earlier results drain so the new prediction stands alone.
                while (pending_results.size() != 0) @(negedge i_clk);
                send_item(row.it);
                if (pending_results.size() != 1 || pending_results[0].status !== row.check) begin
                    $display("%0t: directed row %0d expected status %0d", $time, k, row.check);
                    fail_count++;
                end
            end else begin
                send_item(row.it);
            end
        end

        // Inactive pids and narrow columns, including out-of-range settings.
        write_register(CFG_ACT_PROC, 4'd3);
        write_register(CFG_ACT_RES, 4'd1);
        send_item(make_item(OP_LOAD_ROW, 5, 1, 1, 1, 1, 9, 9, 9, 9));
        send_item(make_item(OP_REQUEST, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_RELEASE, 6, 0, 3, 0, 1, 0, 0, 0, 0));
        send_item(make_item(OP_REQUEST, 1, 1, 9, 9, 9, 0, 0, 0, 0));
        write_register(CFG_ACT_PROC, 4'd0);
        write_register(CFG_ACT_RES, 4'd7);
        send_item(make_item(OP_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        write_register(CFG_ACT_PROC, 4'd15);
        write_register(CFG_ACT_RES, 4'd0);
        send_item(make_item(OP_REQUEST, 7, 0, 0, 0, 0, 0, 0, 0, 0));

        // Random phases over several settings, extremes included.
        idle_enable = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_register(CFG_ACT_PROC, 4'd8); write_register(CFG_ACT_RES, 4'd4); end
                1: begin write_register(CFG_ACT_PROC, 4'd1); write_register(CFG_ACT_RES, 4'd1); end
                2: begin write_register(CFG_ACT_PROC, 4'd5); write_register(CFG_ACT_RES, 4'd2); end
                3: begin write_register(CFG_ACT_PROC, 4'd8); write_register(CFG_ACT_RES, 4'd3); end
                4: begin write_register(CFG_ACT_PROC, 4'd9); write_register(CFG_ACT_RES, 4'd5); end
                default: begin
                    write_register(CFG_ACT_PROC, 4'd8);
                    write_register(CFG_ACT_RES, 4'd4);
                    idle_enable = 1'b0;
                end
            endcase
            // Long receiver hold-off while requests keep coming.
            if (ph == 2) hold_off = 1'b1;
            for (int n = 0; n < 68; n++) begin
                it = random_item();
                send_item(it);
            end
        end

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("Covered %0d results, %0d evictions, over six register settings.",
                 result_count, evict_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #60000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
